>>> rtl/serial_frame_flush_detector_unit_defines.svh
// ---------------------------------------------------------------------------
// Frame flush detector assertion macros
// Concurrent check helpers used at the top level; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_FLUSH_DETECTOR_UNIT_DEFINES_SVH
`define SERIAL_FRAME_FLUSH_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SFFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sffd check failed");
`define SFFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sffd check failed");
`else
`define SFFD_ASSERT_SAME(lbl, ante, cons)
`define SFFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/sffd_pkg.sv
// ---------------------------------------------------------------------------
// Frame flush detector package
// Shared widths, register indexes, mode and cause codes, result type.
// ---------------------------------------------------------------------------
`default_nettype none

package sffd_pkg;

  localparam int SIZE_LIMIT = 64;
  localparam int PEND_W     = $clog2(SIZE_LIMIT + 1);
  localparam int LEN_W      = 7;
  localparam int CAUSE_W    = 2;
  localparam int MODE_W     = 2;
  localparam int DLEN_W     = 3;
  localparam int TMO_W      = 16;
  localparam int PAT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FLUSH_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_MASK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TGT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMATCH_VAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO    = 3'd5;

  localparam logic [MODE_W-1:0] MODE_IMMEDIATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HEADER    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRAILER   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TMO_SIZE  = 2'd3;

  localparam logic [CAUSE_W-1:0] CAUSE_MATCH     = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_IDLE      = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_SIZE      = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_IMMEDIATE = 2'd3;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PEND_W-1:0] pend_t;

  typedef struct packed {
    len_t               flush_length;
    logic [CAUSE_W-1:0] flush_cause;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/sffd_front.sv
// ---------------------------------------------------------------------------
// Frame flush detector front end
// Holds configuration and segmenter state, classifies each transaction and
// pushes any flush result into the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module sffd_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [sffd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sffd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              acc,
  input  wire logic                              action,
  input  wire logic [7:0]                        data_byte,
  output sffd_pkg::res_t                         res,
  output logic                                   res_vld
);

  logic [sffd_pkg::MODE_W-1:0] mode_r;
  logic [sffd_pkg::PAT_W-1:0]  mask_r;
  logic [sffd_pkg::PAT_W-1:0]  target_r;
  logic [sffd_pkg::PAT_W-1:0]  unmatch_r;
  logic [sffd_pkg::DLEN_W-1:0] dlen_r;
  logic [sffd_pkg::TMO_W-1:0]  tmo_r;

  logic [sffd_pkg::PAT_W-1:0]  pat_r, pat_nxt;
  sffd_pkg::pend_t             pend_r, pend_nxt;
  logic [sffd_pkg::TMO_W-1:0]  idle_r, idle_nxt;

  logic [sffd_pkg::TMO_W-1:0]  idle_dec;
  logic [sffd_pkg::PEND_W:0]   pend_inc;
  logic [sffd_pkg::PEND_W:0]   dlen_ext;
  logic [sffd_pkg::PEND_W:0]   pend_mid;
  logic [sffd_pkg::PAT_W-1:0]  pat_sh;
  logic                        delim_mode;
  logic                        match;
  logic                        hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= sffd_pkg::MODE_IMMEDIATE;
      mask_r    <= '0;
      target_r  <= '0;
      unmatch_r <= '0;
      dlen_r    <= '0;
      tmo_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sffd_pkg::REG_FLUSH_MODE:  mode_r    <= cfg_wdata[sffd_pkg::MODE_W-1:0];
        sffd_pkg::REG_MATCH_MASK:  mask_r    <= cfg_wdata[sffd_pkg::PAT_W-1:0];
        sffd_pkg::REG_MATCH_TGT:   target_r  <= cfg_wdata[sffd_pkg::PAT_W-1:0];
        sffd_pkg::REG_UNMATCH_VAL: unmatch_r <= cfg_wdata[sffd_pkg::PAT_W-1:0];
        sffd_pkg::REG_DELIM_LEN:   dlen_r    <= cfg_wdata[sffd_pkg::DLEN_W-1:0];
        sffd_pkg::REG_IDLE_TMO:    tmo_r     <= cfg_wdata[sffd_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pat_nxt    = pat_r;
    pend_nxt   = pend_r;
    idle_nxt   = idle_r;
    res_vld    = 1'b0;
    res        = '0;
    idle_dec   = (idle_r != '0) ? idle_r - 1'b1 : idle_r;
    pend_inc   = {1'b0, pend_r} + 1'b1;
    dlen_ext   = (sffd_pkg::PEND_W + 1)'(dlen_r);
    delim_mode = (mode_r == sffd_pkg::MODE_HEADER) || (mode_r == sffd_pkg::MODE_TRAILER);
    pat_sh     = delim_mode ? {pat_r[sffd_pkg::PAT_W-9:0], data_byte} : pat_r;
    match      = delim_mode && (mask_r != '0) && ((pat_sh & mask_r) == target_r);
    pend_mid   = pend_inc;
    hit        = 1'b0;

    if (action == sffd_pkg::ACT_TICK) begin
      idle_nxt = idle_dec;
      if (idle_dec == '0 && pend_r != '0) begin
        res_vld              = 1'b1;
        res.flush_length     = sffd_pkg::len_t'(pend_r);
        res.flush_cause      = (mode_r == sffd_pkg::MODE_IMMEDIATE) ?
                               sffd_pkg::CAUSE_IMMEDIATE : sffd_pkg::CAUSE_IDLE;
        pend_nxt             = '0;
        pat_nxt              = unmatch_r;
      end
    end else if (mode_r == sffd_pkg::MODE_IMMEDIATE) begin
      res_vld          = 1'b1;
      res.flush_length = sffd_pkg::len_t'(pend_inc);
      res.flush_cause  = sffd_pkg::CAUSE_IMMEDIATE;
      pend_nxt         = '0;
      pat_nxt          = unmatch_r;
    end else begin
      idle_nxt = tmo_r;
      pat_nxt  = pat_sh;
      if (match) begin
        pat_nxt = unmatch_r;
        if (mode_r == sffd_pkg::MODE_TRAILER) begin
          hit              = 1'b1;
          res.flush_length = sffd_pkg::len_t'(pend_inc);
          pend_mid         = '0;
        end else if (pend_inc > dlen_ext) begin
          hit              = 1'b1;
          res.flush_length = sffd_pkg::len_t'(pend_inc - dlen_ext);
          pend_mid         = dlen_ext;
        end
        res.flush_cause = sffd_pkg::CAUSE_MATCH;
      end
      if (!hit && pend_mid >= (sffd_pkg::PEND_W + 1)'(sffd_pkg::SIZE_LIMIT)) begin
        hit              = 1'b1;
        res.flush_length = sffd_pkg::len_t'(sffd_pkg::SIZE_LIMIT);
        res.flush_cause  = sffd_pkg::CAUSE_SIZE;
        pend_mid         = pend_mid - (sffd_pkg::PEND_W + 1)'(sffd_pkg::SIZE_LIMIT);
        pat_nxt          = unmatch_r;
      end
      res_vld  = hit;
      pend_nxt = pend_mid[sffd_pkg::PEND_W-1:0];
    end
    if (!acc) begin
      res_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      pend_r <= '0;
      idle_r <= '0;
    end else if (acc) begin
      pat_r  <= pat_nxt;
      pend_r <= pend_nxt;
      idle_r <= idle_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sffd_queue.sv
// ---------------------------------------------------------------------------
// Frame flush detector result queue
// Short FIFO between the front end and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module sffd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sffd_pkg::res_t  push_data,
  output logic                 full,
  output logic                 pop_vld,
  input  wire logic            pop_rdy,
  output sffd_pkg::res_t       pop_data
);

  sffd_pkg::res_t                 mem_r [sffd_pkg::Q_DEPTH];
  logic [sffd_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [sffd_pkg::Q_CNT_W-1:0]   cnt_r;
  logic                           pop;

  assign full     = (cnt_r == sffd_pkg::Q_CNT_W'(sffd_pkg::Q_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop      = pop_vld && pop_rdy;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == sffd_pkg::Q_PTR_W'(sffd_pkg::Q_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == sffd_pkg::Q_PTR_W'(sffd_pkg::Q_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/serial_frame_flush_detector_unit.sv
// ---------------------------------------------------------------------------
// Serial frame flush detector
// Splits a received byte stream into frames on delimiters, idle time and
// size, or per byte in immediate mode; reports each frame's length and cause.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per byte (in_action = 0) or timer tick (1).
//   out_* : one transaction per flush: out_flush_length bytes, out_flush_cause.
//   cfg_* : single-cycle register writes, index per register list, no read.
// Result: a flush caused by a transaction is queued when the transaction is
//   accepted and appears on out_* from the queue; transactions that cause no flush produce nothing.
// Throughput: one transaction per cycle while in_ready is high; the segmenter
//   state is computed combinationally and registered in the front end.
// Stall: results wait in a two-entry queue; in_ready drops while the queue
//   is full, which a one-cycle receiver stall causes when every transaction
//   flushes.
// Reset: synchronous, active low; clears registers, state and the queue.
//   No clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "serial_frame_flush_detector_unit_defines.svh"

module serial_frame_flush_detector_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [sffd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sffd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_action,
  input  wire logic [7:0]                        in_data_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sffd_pkg::LEN_W-1:0]             out_flush_length,
  output logic [sffd_pkg::CAUSE_W-1:0]           out_flush_cause
);

  sffd_pkg::res_t res, q_data;
  logic           res_vld;
  logic           q_full;
  logic           acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  sffd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .action    (in_action),
    .data_byte (in_data_byte),
    .res       (res),
    .res_vld   (res_vld)
  );

  sffd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (q_full),
    .pop_vld   (out_valid),
    .pop_rdy   (out_ready),
    .pop_data  (q_data)
  );

  assign out_flush_length = q_data.flush_length;
  assign out_flush_cause  = q_data.flush_cause;

  `SFFD_ASSERT_SAME(a_stall_only_full, !in_ready, out_valid)
  `SFFD_ASSERT_SAME(a_len_nonzero, out_valid, out_flush_length != '0)
  `SFFD_ASSERT_SAME(a_size_len, out_valid && out_flush_cause == sffd_pkg::CAUSE_SIZE, out_flush_length == sffd_pkg::LEN_W'(sffd_pkg::SIZE_LIMIT))
  `SFFD_ASSERT_NEXT(a_result_arrives, res_vld && !out_valid, out_valid)

endmodule

`default_nettype wire
